@@ rtl/mos_pkg.sv @@
// Package for the metronome onset scheduler: payload structs, sizes and state codes.
// Depends on nothing; imported by the scheduler core.
`timescale 1ns / 1ps

package mos_pkg;

	// Largest number of onsets reported for one audio block.
	localparam int MAX_ONSETS = 16;
	localparam int CNT_W      = $clog2(MAX_ONSETS + 1);

	// Absolute phase positions and the shared divider widths.
	localparam int POS_W  = 27;
	localparam int NUM_W  = 36;
	localparam int DEN_W  = 24;
	localparam int DSTEPS = NUM_W;
	localparam int DCNT_W = $clog2(DSTEPS);

	// Division jobs run on the shared divider, in this order.
	localparam logic [1:0] DIV_BEAT_PHASE  = 2'd0;
	localparam logic [1:0] DIV_BEAT_FIRST  = 2'd1;
	localparam logic [1:0] DIV_BEAT_STEP   = 2'd2;
	localparam logic [1:0] DIV_ACCENT_FIRST = 2'd3;

	typedef struct packed {
		logic [23:0] interval_length;
		logic [10:0] beats_per_interval;
		logic [15:0] frame_count;
		logic [23:0] interval_position;
	} mos_in_t;

	typedef struct packed {
		logic        valid_res;
		logic        generation_reset;
		logic        has_onset;
		logic [15:0] onset_offset;
		logic        accent;
		logic        last;
	} mos_out_t;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_DLOAD  = 8'b0000_0010,
		ST_DSTEP  = 8'b0000_0100,
		ST_DSTORE = 8'b0000_1000,
		ST_CNTB   = 8'b0001_0000,
		ST_CNTA   = 8'b0010_0000,
		ST_EMIT   = 8'b0100_0000,
		ST_FIN    = 8'b1000_0000
	} mos_state_t;

endpackage

@@ rtl/metronome_onset_scheduler_core.sv @@
// Metronome onset scheduler core: sequencer around one shared restoring divider.
// Depends on mos_pkg for payload structs, sizes and state codes.
`timescale 1ns / 1ps

// Usage:
// An audio block description enters on item (item_valid / item_ready). The block
// answers on onset (onset_valid / onset_ready) with one transaction per onset in
// ascending offset order, the final one flagged by last. An unusable block (zero
// length, beats or frames) or a block with no onsets gives a single transaction.
// latency_we writes the output latency register with no wait.
// Timing: item_ready is high only while the sequencer is idle. A usable item runs
// four divisions on the shared divider, each a load, 36 bit steps and a store,
// then a counting pass over beats and then accents, then emits one result per
// cycle while onset_ready is high. An unusable item skips the divisions and goes
// straight to the single-result state.
// The result register lets the next item be accepted while the final result of
// the previous one still waits. A stalled receiver holds the sequencer in its
// emitting state. Reset clears the primed flag, the stored length and beats, the
// latency register and all handshake state; no clearing pass is needed.
module metronome_onset_scheduler_core
	import mos_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  mos_in_t     item,
	output logic        onset_valid,
	input  logic        onset_ready,
	output mos_out_t    onset,
	input  logic        latency_we,
	input  logic [15:0] latency_wdata
);

	mos_state_t        state_q;
	logic [15:0]       latency_q;
	logic              primed_q;
	logic [23:0]       last_len_q;
	logic [10:0]       last_bpi_q;

	logic [23:0]       len_q;
	logic [10:0]       bpi_q;
	logic [POS_W-1:0]  start_q;
	logic [POS_W-1:0]  end_q;
	logic              gen_q;
	logic              fin_valid_q;

	logic [1:0]        sel_q;
	logic [NUM_W-1:0]  div_num_q;
	logic [DEN_W-1:0]  div_den_q;
	logic [DEN_W:0]    div_rem_q;
	logic [DCNT_W-1:0] div_cnt_q;
	logic [23:0]       e_q;

	logic [POS_W-1:0]  bq_q, bq_i_q, aq_q, aq_i_q;
	logic [10:0]       br_q, br_i_q;
	logic [23:0]       stepq_q;
	logic [10:0]       stepr_q;
	logic [CNT_W-1:0]  nb_q, na_q, i_q, j_q;

	logic              out_valid_q;
	mos_out_t          out_q;

	logic              accept;
	logic              in_ok;
	logic              slot_free;
	logic [NUM_W-1:0]  prod;
	logic [DEN_W:0]    rem_sh;
	logic              rem_ge;
	logic [11:0]       br_sum;
	logic              br_wrap;
	logic [10:0]       br_nx;
	logic [POS_W-1:0]  bq_nx;
	logic [CNT_W:0]    tot;
	logic              take_beat;
	logic              is_last;
	logic [23:0]       rem_lo;
	logic [23:0]       gap;

	assign accept      = item_valid && item_ready;
	assign item_ready  = (state_q == ST_IDLE);
	assign onset_valid = out_valid_q;
	assign onset       = out_q;
	assign slot_free   = !out_valid_q || onset_ready;
	assign in_ok       = (item.interval_length != '0) && (item.beats_per_interval != '0) &&
		(item.frame_count != '0);

	// Phase numerator for the first beat: start times beats.
	assign prod = start_q[24:0] * bpi_q;

	// One restoring divider step.
	assign rem_sh = {div_rem_q[DEN_W-1:0], div_num_q[NUM_W-1]};
	assign rem_ge = rem_sh >= {1'b0, div_den_q};

	// Distance from a remainder up to the next multiple of the length.
	assign rem_lo = div_rem_q[23:0];
	assign gap    = (rem_lo == '0) ? 24'd0 : (len_q - rem_lo);

	// Next beat position: quotient step plus remainder carry.
	assign br_sum  = {1'b0, br_q} + {1'b0, stepr_q};
	assign br_wrap = br_sum >= {1'b0, bpi_q};
	assign br_nx   = br_wrap ? 11'(br_sum - {1'b0, bpi_q}) : br_sum[10:0];
	assign bq_nx   = bq_q + POS_W'(stepq_q) + POS_W'(br_wrap);

	// Merge choice between the next beat and the next accent.
	assign tot       = {1'b0, nb_q} + {1'b0, na_q};
	assign take_beat = (j_q >= na_q) || ((i_q < nb_q) && (bq_q <= aq_q));
	assign is_last   = ({1'b0, i_q} + {1'b0, j_q} + (CNT_W+1)'(1)) == tot;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latency_q <= '0;
		end else if (latency_we) begin
			latency_q <= latency_wdata;
		end
	end

	// Sequencer, divider and onset iterators.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			primed_q   <= 1'b0;
			last_len_q <= '0;
			last_bpi_q <= '0;
			sel_q      <= '0;
			div_cnt_q  <= '0;
			nb_q       <= '0;
			na_q       <= '0;
			i_q        <= '0;
			j_q        <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						len_q       <= item.interval_length;
						bpi_q       <= item.beats_per_interval;
						start_q     <= POS_W'(item.interval_position) + POS_W'(latency_q);
						end_q       <= POS_W'(item.interval_position) + POS_W'(latency_q) +
							POS_W'(item.frame_count) - POS_W'(1);
						nb_q        <= '0;
						na_q        <= '0;
						sel_q       <= DIV_BEAT_PHASE;
						if (in_ok) begin
							gen_q       <= !primed_q || (last_len_q != item.interval_length) ||
								(last_bpi_q != item.beats_per_interval);
							fin_valid_q <= 1'b1;
							primed_q    <= 1'b1;
							last_len_q  <= item.interval_length;
							last_bpi_q  <= item.beats_per_interval;
							state_q     <= ST_DLOAD;
						end else begin
							gen_q       <= 1'b0;
							fin_valid_q <= 1'b0;
							primed_q    <= 1'b0;
							state_q     <= ST_FIN;
						end
					end
				end
				ST_DLOAD: begin
					div_rem_q <= '0;
					div_cnt_q <= '0;
					case (sel_q)
						DIV_BEAT_PHASE: begin
							div_num_q <= prod;
							div_den_q <= len_q;
						end
						DIV_BEAT_FIRST: begin
							div_num_q <= NUM_W'(e_q);
							div_den_q <= DEN_W'(bpi_q);
						end
						DIV_BEAT_STEP: begin
							div_num_q <= NUM_W'(len_q);
							div_den_q <= DEN_W'(bpi_q);
						end
						default: begin
							div_num_q <= NUM_W'(start_q[24:0]);
							div_den_q <= len_q;
						end
					endcase
					state_q <= ST_DSTEP;
				end
				ST_DSTEP: begin
					div_rem_q <= rem_ge ? (rem_sh - {1'b0, div_den_q}) : rem_sh;
					div_num_q <= {div_num_q[NUM_W-2:0], rem_ge};
					div_cnt_q <= div_cnt_q + DCNT_W'(1);
					if (div_cnt_q == DCNT_W'(DSTEPS - 1)) begin
						state_q <= ST_DSTORE;
					end
				end
				ST_DSTORE: begin
					case (sel_q)
						DIV_BEAT_PHASE: begin
							e_q <= gap;
						end
						DIV_BEAT_FIRST: begin
							bq_q   <= start_q + POS_W'(div_num_q[23:0]);
							bq_i_q <= start_q + POS_W'(div_num_q[23:0]);
							br_q   <= div_rem_q[10:0];
							br_i_q <= div_rem_q[10:0];
						end
						DIV_BEAT_STEP: begin
							stepq_q <= div_num_q[23:0];
							stepr_q <= div_rem_q[10:0];
						end
						default: begin
							aq_q   <= start_q + POS_W'(gap);
							aq_i_q <= start_q + POS_W'(gap);
						end
					endcase
					if (sel_q == DIV_ACCENT_FIRST) begin
						state_q <= ST_CNTB;
					end else begin
						sel_q   <= sel_q + 2'd1;
						state_q <= ST_DLOAD;
					end
				end
				ST_CNTB: begin
					// Count beats in the window, up to the onset limit.
					if ((nb_q < CNT_W'(MAX_ONSETS)) && (bq_q <= end_q)) begin
						nb_q <= nb_q + CNT_W'(1);
						bq_q <= bq_nx;
						br_q <= br_nx;
					end else begin
						state_q <= ST_CNTA;
					end
				end
				ST_CNTA: begin
					// Accents fill the slots the beats leave.
					if ((tot < (CNT_W+1)'(MAX_ONSETS)) && (aq_q <= end_q)) begin
						na_q <= na_q + CNT_W'(1);
						aq_q <= aq_q + POS_W'(len_q);
					end else begin
						bq_q <= bq_i_q;
						br_q <= br_i_q;
						aq_q <= aq_i_q;
						i_q  <= '0;
						j_q  <= '0;
						state_q <= (tot == '0) ? ST_FIN : ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						if (take_beat) begin
							i_q  <= i_q + CNT_W'(1);
							bq_q <= bq_nx;
							br_q <= br_nx;
						end else begin
							j_q  <= j_q + CNT_W'(1);
							aq_q <= aq_q + POS_W'(len_q);
						end
						if (is_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_FIN: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			if (state_q == ST_EMIT) begin
				out_valid_q <= 1'b1;
			end else if (state_q == ST_FIN) begin
				out_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (slot_free && (state_q == ST_EMIT)) begin
			out_q.valid_res        <= 1'b1;
			out_q.generation_reset <= gen_q;
			out_q.has_onset        <= 1'b1;
			out_q.onset_offset     <= take_beat ? 16'(bq_q - start_q) : 16'(aq_q - start_q);
			out_q.accent           <= !take_beat;
			out_q.last             <= is_last;
		end else if (slot_free && (state_q == ST_FIN)) begin
			out_q.valid_res        <= fin_valid_q;
			out_q.generation_reset <= gen_q;
			out_q.has_onset        <= 1'b0;
			out_q.onset_offset     <= '0;
			out_q.accent           <= 1'b0;
			out_q.last             <= 1'b1;
		end
	end

	// The onset count never passes the limit.
	assert property (@(posedge clk) disable iff (!arst_n)
		tot <= (CNT_W+1)'(MAX_ONSETS))
		else $error("onset count above limit");

	// While emitting, the merge indexes stay inside the counted lists.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> ((i_q <= nb_q) && (j_q <= na_q)))
		else $error("merge index past its list");

	// An unusable item goes straight to the single-result state.
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !in_ok) |=> (state_q == ST_FIN) && !fin_valid_q && !primed_q)
		else $error("unusable item not rejected");

	// The divider remainder stays below the divisor.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DSTEP) |-> (div_rem_q < {1'b0, div_den_q}))
		else $error("divider remainder out of range");

endmodule

@@ sim/tb_metronome_onset_scheduler_core.sv @@
// Testbench for the metronome onset scheduler core: directed table, then random blocks.
// Depends on mos_pkg and metronome_onset_scheduler_core; results are predicted in-bench.
`timescale 1ns / 1ps

module tb_metronome_onset_scheduler_core;
	import mos_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 300;
	localparam int N_RANDOM       = 360;

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_ready;
	mos_in_t     item;
	logic        onset_valid;
	logic        onset_ready;
	mos_out_t    onset;
	logic        latency_we;
	logic [15:0] latency_wdata;

	// Predictor state and the queue of onsets still owed by the core.
	logic [15:0] lat_model;
	bit          primed_model;
	logic [23:0] len_model;
	logic [10:0] beats_model;
	mos_out_t    onset_q[$];

	int error_count;
	int idle_cycles;
	int send_idle_pct;
	int recv_idle_pct;
	bit timed_out;

	// One directed row: item, optional typed-in expectation of a single result.
	typedef struct {
		mos_in_t  blk;
		bit       has_exp;
		mos_out_t exp_res;
	} dir_row_t;

	dir_row_t dir_rows[$];

	metronome_onset_scheduler_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.onset_valid  (onset_valid),
		.onset_ready  (onset_ready),
		.onset        (onset),
		.latency_we   (latency_we),
		.latency_wdata(latency_wdata)
	);

	// Clock with a 10 ns period.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		$display("ERROR %0t: %s", $realtime, what);
		error_count++;
	endtask

	// Compute the onsets of one audio block and append them to the queue.
	function automatic void predict_onsets(input mos_in_t blk);
		logic [63:0] len, bpi, frames, start, stop, idx, b;
		logic [63:0] beat_off[MAX_ONSETS];
		logic [63:0] acc_off[MAX_ONSETS];
		int nb, na, i, j, n;
		bit gen, take_beat;
		mos_out_t r;
		len = 64'(blk.interval_length);
		bpi = 64'(blk.beats_per_interval);
		frames = 64'(blk.frame_count);
		nb = 0;
		na = 0;
		i = 0;
		j = 0;
		n = 0;
		r = '0;
		if (len == 0 || bpi == 0 || frames == 0) begin
			primed_model = 1'b0;
			r.last = 1'b1;
			onset_q.push_back(r);
			return;
		end
		gen = !primed_model || len_model != blk.interval_length ||
			beats_model != blk.beats_per_interval;
		primed_model = 1'b1;
		len_model = blk.interval_length;
		beats_model = blk.beats_per_interval;
		start = 64'(blk.interval_position) + 64'(lat_model);
		stop = start + frames - 64'd1;
		// Beats first, from the first beat index at or after the window start.
		idx = (start * bpi + len - 64'd1) / len;
		while (nb < MAX_ONSETS) begin
			b = (idx * len) / bpi;
			if (b > stop) break;
			beat_off[nb++] = b - start;
			idx++;
		end
		// Accents fill whatever slots remain.
		idx = (start + len - 64'd1) / len;
		while (nb + na < MAX_ONSETS) begin
			b = idx * len;
			if (b > stop) break;
			acc_off[na++] = b - start;
			idx++;
		end
		r.valid_res = 1'b1;
		r.generation_reset = gen;
		if (nb + na == 0) begin
			r.last = 1'b1;
			onset_q.push_back(r);
			return;
		end
		// Merge in ascending order; a beat wins a tie with an accent.
		while (i < nb || j < na) begin
			take_beat = (j >= na) || (i < nb && beat_off[i] <= acc_off[j]);
			r.has_onset = 1'b1;
			r.last = (n == nb + na - 1);
			if (take_beat) begin
				r.onset_offset = beat_off[i][15:0];
				r.accent = 1'b0;
				i++;
			end else begin
				r.onset_offset = acc_off[j][15:0];
				r.accent = 1'b1;
				j++;
			end
			onset_q.push_back(r);
			n++;
		end
	endfunction

	// Present one item and hold it until the core takes it.
	task automatic send_block(input mos_in_t blk);
		@(negedge clk);
		while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct)
			@(negedge clk);
		item <= blk;
		item_valid <= 1'b1;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		predict_onsets(blk);
		@(negedge clk);
		item_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (onset_q.size() != 0 && !timed_out) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_latency(input logic [15:0] value);
		latency_we <= 1'b1;
		latency_wdata <= value;
		lat_model = value;
		@(negedge clk);
		latency_we <= 1'b0;
	endtask

	function automatic mos_in_t make_block(input int len, input int bpi,
		input int frames, input int pos);
		mos_in_t blk;
		blk.interval_length = len[23:0];
		blk.beats_per_interval = bpi[10:0];
		blk.frame_count = frames[15:0];
		blk.interval_position = pos[23:0];
		return blk;
	endfunction

	function automatic void add_row(input mos_in_t blk, input bit has_exp,
		input mos_out_t exp_res);
		dir_row_t row;
		row.blk = blk;
		row.has_exp = has_exp;
		row.exp_res = exp_res;
		dir_rows.push_back(row);
	endfunction

	// Random block: mostly musical sizes, some full-range noise and invalid fields.
	function automatic mos_in_t rand_block();
		mos_in_t blk;
		int kind;
		kind = $urandom_range(99, 0);
		blk.interval_length = 24'($urandom_range(4000, 16));
		blk.beats_per_interval = 11'($urandom_range(16, 1));
		blk.frame_count = 16'($urandom_range(512, 1));
		blk.interval_position = 24'($urandom_range(32'(blk.interval_length) - 1, 0));
		if (kind < 8) begin
			blk.interval_length = 24'($urandom);
			blk.beats_per_interval = 11'($urandom);
			blk.frame_count = 16'($urandom);
			blk.interval_position = 24'($urandom);
		end else if (kind < 14) begin
			case ($urandom_range(2, 0))
				0: blk.interval_length = '0;
				1: blk.beats_per_interval = '0;
				default: blk.frame_count = '0;
			endcase
		end else if (kind < 22) begin
			blk.interval_length = 24'($urandom_range(12, 1));
			blk.beats_per_interval = 11'($urandom);
		end else if (kind < 28) begin
			blk.frame_count = 16'($urandom);
		end
		return blk;
	endfunction

	// Receiver: random stalls, checks each transaction against the oldest onset.
	always @(negedge clk) begin
		onset_ready <= !(recv_idle_pct > 0 && $urandom_range(99, 0) < recv_idle_pct);
	end

	always @(posedge clk) begin
		mos_out_t want;
		if (arst_n && onset_valid && onset_ready) begin
			if (onset_q.size() == 0) begin
				report_mismatch($sformatf("unexpected onset transaction %p", onset));
			end else begin
				want = onset_q.pop_front();
				if (onset.valid_res !== want.valid_res)
					report_mismatch($sformatf("valid_res %b, want %b",
						onset.valid_res, want.valid_res));
				if (onset.generation_reset !== want.generation_reset)
					report_mismatch($sformatf("generation_reset %b, want %b",
						onset.generation_reset, want.generation_reset));
				if (onset.has_onset !== want.has_onset)
					report_mismatch($sformatf("has_onset %b, want %b",
						onset.has_onset, want.has_onset));
				if (onset.onset_offset !== want.onset_offset)
					report_mismatch($sformatf("onset_offset %0d, want %0d",
						onset.onset_offset, want.onset_offset));
				if (onset.accent !== want.accent)
					report_mismatch($sformatf("accent %b, want %b",
						onset.accent, want.accent));
				if (onset.last !== want.last)
					report_mismatch($sformatf("last %b, want %b",
						onset.last, want.last));
			end
		end
	end

	// Watchdog on cycles with no transaction on either channel.
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (onset_valid && onset_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
			timed_out = 1'b1;
			$display("tb_metronome_onset_scheduler_core: FAIL");
			$finish;
		end
	end

	initial begin
		mos_out_t exp_res;
		item_valid = 1'b0;
		item = '0;
		onset_ready = 1'b0;
		latency_we = 1'b0;
		latency_wdata = '0;
		lat_model = '0;
		primed_model = 1'b0;
		len_model = '0;
		beats_model = '0;
		error_count = 0;
		idle_cycles = 0;
		timed_out = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		arst_n = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// Directed table: the invalid-field cases are typed in; the other rows are only predicted.
		exp_res = '0;
		exp_res.last = 1'b1;
		add_row(make_block(0, 4, 100, 0), 1'b1, exp_res);
		add_row(make_block(100, 0, 100, 0), 1'b1, exp_res);
		add_row(make_block(100, 4, 0, 0), 1'b1, exp_res);
		// First valid block: beat then accent at offset zero.
		exp_res = '0;
		exp_res.valid_res = 1'b1;
		exp_res.generation_reset = 1'b1;
		exp_res.has_onset = 1'b1;
		exp_res.last = 1'b0;
		add_row(make_block(1000, 4, 1, 0), 1'b0, exp_res);
		add_row(make_block(1000, 4, 100, 1), 1'b0, exp_res);
		add_row(make_block(1000, 4, 2000, 0), 1'b0, exp_res);
		add_row(make_block(3, 10, 20, 0), 1'b0, exp_res);
		add_row(make_block(1, 2047, 4, 0), 1'b0, exp_res);
		add_row(make_block(16777215, 2047, 65535, 16777215), 1'b0, exp_res);
		add_row(make_block(16777215, 1, 65535, 16777000), 1'b0, exp_res);
		add_row(make_block(1, 1, 65535, 0), 1'b0, exp_res);
		add_row(make_block(65535, 1024, 65535, 12345), 1'b0, exp_res);
		add_row(make_block(700, 7, 699, 1), 1'b0, exp_res);
		add_row(make_block(700, 7, 699, 1), 1'b0, exp_res);
		add_row(make_block(5592405, 1365, 43690, 11184810), 1'b0, exp_res);
		add_row(make_block(16777215, 1024, 1, 0), 1'b0, exp_res);

		// Typed-in rows also pin the queued expectation, which the checker holds the core to.
		foreach (dir_rows[r]) begin
			send_block(dir_rows[r].blk);
			if (dir_rows[r].has_exp) begin
				if (onset_q.size() == 0 || onset_q[$] !== dir_rows[r].exp_res)
					report_mismatch("typed-in result differs from the prediction");
				wait_drained();
			end
		end
		wait_drained();

		// Latency at its top value, then random phases with different idling.
		write_latency(16'hFFFF);
		send_block(make_block(70000, 3, 200, 16777215));
		send_block(make_block(1000, 1024, 65535, 0));
		wait_drained();
		write_latency(16'h0000);
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin send_idle_pct = 23; recv_idle_pct = 54; end
				1: begin send_idle_pct = 54; recv_idle_pct = 23; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			for (int k = 0; k < N_RANDOM / 3; k++) begin
				send_block(rand_block());
				if (k == 40) wait_drained();
			end
			wait_drained();
			write_latency(16'($urandom_range(65535, 0)));
		end
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (10) send_block(rand_block());
		wait_drained();

		if (error_count == 0 && onset_q.size() == 0)
			$display("tb_metronome_onset_scheduler_core: PASS");
		else
			$display("tb_metronome_onset_scheduler_core: FAIL");
		$finish;
	end

endmodule

@@ metronome_onset_scheduler_core.f @@
rtl/mos_pkg.sv
rtl/metronome_onset_scheduler_core.sv
sim/tb_metronome_onset_scheduler_core.sv
